FILE: design/fmb_pkg.sv
// ============================================================================
// fmb_pkg
// Shared types and constants for the factor multiplier bound core.
// ============================================================================
`default_nettype none

package fmb_pkg;

    // Field widths.
    localparam int EXPONENT_W  = 32;
    localparam int BIT_COUNT_W = 7;
    localparam int QUOT_W      = 64;
    localparam int DIVISOR_W   = EXPONENT_W;

    // Division pipeline shape: restoring steps per register stage.
    localparam int STEPS_PER_STAGE = 4;
    localparam int DIV_STAGES      = QUOT_W / STEPS_PER_STAGE;

    // Request to result: setup stage, divider stages, output register.
    localparam int LATENCY = DIV_STAGES + 2;

    // Bit count limits.
    localparam logic [BIT_COUNT_W-1:0] MAX_BITS   = 7'd96;
    localparam logic [BIT_COUNT_W-1:0] SPLIT_BITS = 7'd64;
    localparam logic [BIT_COUNT_W-1:0] OVF_BASE   = 7'd65;

    typedef struct packed {
        logic [EXPONENT_W-1:0]  exponent;
        logic [BIT_COUNT_W-1:0] bit_count;
    } t_request;

    typedef struct packed {
        logic [QUOT_W-1:0] k_bound;
        logic              bad_input;
    } t_result;

    // State carried down the divider pipeline. The word holds the dividend
    // bits still to be consumed at the top and the quotient bits gathered at
    // the bottom.
    typedef struct packed {
        logic                 valid;
        logic                 force_one;
        logic                 bad_input;
        logic [DIVISOR_W-1:0] divisor;
        logic [DIVISOR_W-1:0] rem;
        logic [QUOT_W-1:0]    word;
    } t_div_state;

endpackage

`default_nettype wire

FILE: design/fmb_div_stage.sv
// ============================================================================
// fmb_div_stage
// One register stage of the restoring divider, STEPS_PER_STAGE quotient bits per stage.
// ============================================================================
`default_nettype none

module fmb_div_stage (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire fmb_pkg::t_div_state i_state,
    output fmb_pkg::t_div_state     o_state
);
    import fmb_pkg::*;

    t_div_state n_state;
    t_div_state r_state;

    always_comb begin
        logic [DIVISOR_W:0] v_shift;
        logic               v_qbit;
        n_state = i_state;
        for (int j = 0; j < STEPS_PER_STAGE; j++) begin
            v_shift = {n_state.rem, n_state.word[QUOT_W-1]};
            if (v_shift >= {1'b0, n_state.divisor}) begin
                v_shift = v_shift - {1'b0, n_state.divisor};
                v_qbit  = 1'b1;
            end else begin
                v_qbit  = 1'b0;
            end
            // The remainder stays below the divisor, so the top bit is zero.
            n_state.rem  = v_shift[DIVISOR_W-1:0];
            n_state.word = {n_state.word[QUOT_W-2:0], v_qbit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

`default_nettype wire

FILE: design/factor_multiplier_bound_core.sv
// ============================================================================
// factor_multiplier_bound_core
// Largest multiplier k with 2*p*k+1 below 2^b, by a pipelined divider.
// ============================================================================
// A request carries an exponent p and a bit count b and is taken on any clock
// edge where start is high; busy is always low, so a new request may be given
// in every cycle. Each request yields exactly one result, in request order.
// The result is shown on o_res for a single cycle with o_valid high. The
// receiver cannot hold results off and nothing here waits for it. A request
// passes through one setup stage, sixteen divider register stages of four
// of the 64 restoring division steps each, and the output register. The
// result is floor((2^(b-1)-1)/p); it is replaced by 1 when b is above 96,
// when the quotient would reach 2^64 or when it is zero. A zero exponent or
// zero bit count also gives 1, and then bad_input is set.
// ============================================================================
`default_nettype none

module factor_multiplier_bound_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire fmb_pkg::t_request i_req,
    output logic                  o_valid,
    output fmb_pkg::t_result      o_res
);
    import fmb_pkg::*;

    // ------------------------------------------------------------------
    // Setup stage. The dividend is 2^L-1 with L = b-1, a run of ones. When
    // the quotient fits in 64 bits the part of the dividend above bit 63 is
    // smaller than p, so it can seed the remainder directly and only the low
    // 64 dividend bits need a division step each.
    // ------------------------------------------------------------------
    t_div_state n_setup;
    t_div_state r_setup;

    always_comb begin
        logic [BIT_COUNT_W-1:0] v_len;
        logic [BIT_COUNT_W-1:0] v_hi_len;
        logic [BIT_COUNT_W-1:0] v_ovf_amt;
        logic                   v_bad;
        logic                   v_too_wide;
        logic                   v_overflow;
        v_len      = i_req.bit_count - 7'd1;
        v_hi_len   = v_len - SPLIT_BITS;
        v_ovf_amt  = i_req.bit_count - OVF_BASE;
        v_bad      = (i_req.exponent == '0) || (i_req.bit_count == '0);
        v_too_wide = i_req.bit_count > MAX_BITS;
        // The quotient reaches 2^64 exactly when p is below 2^(b-65).
        v_overflow = (i_req.bit_count > OVF_BASE)
                     && ((i_req.exponent >> v_ovf_amt[4:0]) == '0);

        n_setup.valid     = start;
        n_setup.force_one = v_bad || v_too_wide || v_overflow;
        n_setup.bad_input = v_bad;
        n_setup.divisor   = i_req.exponent;
        if (v_len > SPLIT_BITS) begin
            n_setup.rem = (DIVISOR_W'(1) << v_hi_len[4:0]) - DIVISOR_W'(1);
        end else begin
            n_setup.rem = '0;
        end
        if (v_len >= SPLIT_BITS) begin
            n_setup.word = '1;
        end else begin
            n_setup.word = (QUOT_W'(1) << v_len[5:0]) - QUOT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setup <= '0;
        end else begin
            r_setup <= n_setup;
        end
    end

    // ------------------------------------------------------------------
    // Divider pipeline: each stage retires STEPS_PER_STAGE quotient bits.
    // ------------------------------------------------------------------
    t_div_state w_chain [DIV_STAGES+1];

    assign w_chain[0] = r_setup;

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        fmb_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_state (w_chain[g]),
            .o_state (w_chain[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Output register. After the last stage the word holds the quotient.
    // A forced case or a zero quotient becomes 1.
    // ------------------------------------------------------------------
    t_div_state w_last;
    t_result    n_res;
    t_result    r_res;
    logic       r_valid;

    assign w_last = w_chain[DIV_STAGES];

    always_comb begin
        n_res.bad_input = w_last.bad_input;
        if (w_last.force_one || (w_last.word == '0)) begin
            n_res.k_bound = QUOT_W'(1);
        end else begin
            n_res.k_bound = w_last.word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    // Every stage moves on every cycle, so a request is never refused.
    assign busy    = 1'b0;
    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

FILE: design/fmb_checker.sv
// ============================================================================
// fmb_checker
// Port-level checks for the factor multiplier bound core, bound to it.
// ============================================================================
`default_nettype none

module fmb_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire fmb_pkg::t_request i_req,
    input wire logic             o_valid,
    input wire fmb_pkg::t_result o_res
);
    import fmb_pkg::*;

    // Counts clean cycles since reset, saturating at the latency.
    logic [5:0] r_settle;
    logic [5:0] n_settle;
    logic       w_settled;

    assign w_settled = (r_settle == 6'(LATENCY));

    always_comb begin
        n_settle = r_settle;
        if (!w_settled) begin
            n_settle = r_settle + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= '0;
        end else begin
            r_settle <= n_settle;
        end
    end

    // Each request gives a result after exactly the pipeline latency.
    a_req_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_settled && $past(start && !busy, LATENCY) |-> o_valid)
        else $error("request without result");

    // No result appears without a request the latency earlier.
    a_result_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_settled && o_valid |-> $past(start && !busy, LATENCY))
        else $error("result without request");

    // Bad input is flagged exactly for a zero field.
    a_bad_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_settled && o_valid |-> o_res.bad_input ==
            (($past(i_req.exponent, LATENCY) == '0)
             || ($past(i_req.bit_count, LATENCY) == '0)))
        else $error("bad input flag mismatch");

    // The bound is never zero.
    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_res.k_bound != '0)
        else $error("zero bound");

endmodule

bind factor_multiplier_bound_core fmb_checker u_fmb_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_req   (i_req),
    .o_valid (o_valid),
    .o_res   (o_res)
);

`default_nettype wire
